// File: sv/tsq_pkg.sv
// Package for the timed register write sequencer.
// Holds the field widths, the request and write payload types, codes and defaults.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package tsq_pkg;

  // Default storage and per-tick write budget
  localparam int unsigned SONG_DEPTH_DEF = 4096;
  localparam int unsigned MAX_WRITES_DEF = 64;

  // Field widths
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned EVT_W   = 13;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_IDX_W = 2;

  // Request opcodes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } opcode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SONG_EVENTS = 2'd0,
    CFG_PLAY_ENABLE = 2'd1
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } seq_state_e;

  // One input request
  typedef struct packed {
    opcode_e              opcode;
    logic [IDX_W-1:0]     event_index;
    logic [BYTE_W-1:0]    reg_address;
    logic [BYTE_W-1:0]    reg_data;
    logic [DELAY_W-1:0]   delay_ticks;
  } req_t;

  // One emitted register write
  typedef struct packed {
    logic [BYTE_W-1:0] write_address;
    logic [BYTE_W-1:0] write_data;
    logic              last_write;
  } wr_t;

  // One song memory word: delay in the top half, data, then address
  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic [BYTE_W-1:0]  data;
    logic [BYTE_W-1:0]  addr;
  } song_word_t;

endpackage

`default_nettype wire

// File: sv/tsq_if.sv
// Valid/ready channels of the sequencer: request input and register write output.
// Depends on tsq_pkg for the payload types.
`default_nettype none

interface tsq_req_if import tsq_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tsq_wr_if import tsq_pkg::*; ();
  logic valid;
  logic ready;
  wr_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/tsq_song_mem.sv
// Song memory: single write port, single read port with registered read data.
// Depends on tsq_pkg for the song word type and default depth.
`default_nettype none

module tsq_song_mem import tsq_pkg::*; #(
  parameter int unsigned DEPTH = SONG_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire  logic          clk_i,
  input  wire  logic          wr_en_i,
  input  wire  logic [AW-1:0] wr_addr_i,
  input  wire  song_word_t    wr_data_i,
  input  wire  logic          rd_en_i,
  input  wire  logic [AW-1:0] rd_addr_i,
  output       song_word_t    rd_data_o
);

  song_word_t mem_q [DEPTH];
  song_word_t rd_data_q;

  // Store loaded events
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register the read word; hold it between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: sv/timed_register_write_sequencer.sv
// Timed register write sequencer. A load or a tick with nothing due leaves it idle.
// A tick with n due writes (n <= MAX_WRITES_PER_TICK) holds the request side off while
// it emits them: one song memory read ahead, then one write per cycle while the sink keeps
// up, set by the single read port. A returned read word reaches wr_o via the output register.
// Reset clears control registers and position; song memory is undefined until loaded.
`default_nettype none

module timed_register_write_sequencer import tsq_pkg::*; #(
  parameter int unsigned SONG_DEPTH          = SONG_DEPTH_DEF,
  parameter int unsigned MAX_WRITES_PER_TICK = MAX_WRITES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  tsq_req_if.sink                   req_i,
  tsq_wr_if.source                  wr_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned AW      = $clog2(SONG_DEPTH);
  localparam int unsigned CW      = $clog2(MAX_WRITES_PER_TICK + 1);
  localparam int unsigned LEN_CAP = (SONG_DEPTH < 8191) ? SONG_DEPTH : 8191;
  localparam logic [EVT_W-1:0]  LEN_CAP_V = EVT_W'(LEN_CAP);
  localparam logic [AW-1:0]     LAST_POS  = AW'(SONG_DEPTH - 1);
  localparam logic [CW-1:0]     MAX_CNT   = CW'(MAX_WRITES_PER_TICK);
  localparam logic [31:0]       DEPTH_V   = 32'(SONG_DEPTH);

  seq_state_e         state_q, state_d;
  logic [EVT_W-1:0]   song_len_q, song_len_d;
  logic               play_en_q, play_en_d;
  logic [AW-1:0]      rpos_q, rpos_d;
  logic [EVT_W-1:0]   evt_left_q, evt_left_d;
  logic [TICK_W-1:0]  next_due_q, next_due_d;
  logic [TICK_W-1:0]  tick_q, tick_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  wr_t                out_q, out_d;

  logic               req_fire, tick_go, start_due, mem_we, slot_ok;
  logic               emit, more, out_free, rd_en, finish_tick;
  logic [AW-1:0]      rd_addr, rpos_adv;
  logic [EVT_W-1:0]   evt_left_new, cfg_len;
  logic [TICK_W-1:0]  next_due_new;
  logic [CW-1:0]      cnt_inc;
  song_word_t         rd_word, wr_word;

  // Song memory
  tsq_song_mem #(
    .DEPTH (SONG_DEPTH)
  ) u_song_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (AW'(req_i.payload.event_index)),
    .wr_data_i (wr_word),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_word)
  );

  // Decode requests and pack loaded events
  assign req_fire  = req_i.valid && req_i.ready;
  assign tick_go   = req_fire && (req_i.payload.opcode == OP_TICK) && play_en_q;
  assign slot_ok   = {20'd0, req_i.payload.event_index} < DEPTH_V;
  assign mem_we    = req_fire && (req_i.payload.opcode == OP_LOAD) && slot_ok;
  assign wr_word   = '{delay: req_i.payload.delay_ticks,
                       data:  req_i.payload.reg_data,
                       addr:  req_i.payload.reg_address};
  assign start_due = (evt_left_q != '0) && (next_due_q <= tick_q);

  // Work out the event under emission and whether another follows this tick
  assign out_free     = !out_valid_q || wr_o.ready;
  assign next_due_new = tick_q + TICK_W'(rd_word.delay);
  assign evt_left_new = evt_left_q - 1'b1;
  assign rpos_adv     = (rpos_q == LAST_POS) ? '0 : rpos_q + 1'b1;
  assign cnt_inc      = cnt_q + 1'b1;
  assign more         = (evt_left_new != '0) && (next_due_new <= tick_q)
                        && (cnt_inc < MAX_CNT);
  assign cfg_len      = (cfg_data_i > LEN_CAP_V) ? LEN_CAP_V : cfg_data_i;

  // Sequencer outputs
  always_comb begin
    req_i.ready = 1'b0;
    emit        = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = rpos_q;
    finish_tick = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        rd_en       = tick_go && start_due;
        finish_tick = tick_go && !start_due;
      end
      ST_EMIT: begin
        emit        = out_free;
        rd_en       = out_free && more;
        rd_addr     = rpos_adv;
        finish_tick = out_free && !more;
      end
      default: begin
        req_i.ready = 1'b0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (tick_go && start_due) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit && !more) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Playback state update: emit, close the tick, restart on song length or play enable writes
  always_comb begin
    song_len_d = song_len_q;
    play_en_d  = play_en_q;
    rpos_d     = rpos_q;
    evt_left_d = evt_left_q;
    next_due_d = next_due_q;
    tick_d     = tick_q;
    cnt_d      = cnt_q;
    if (tick_go) begin
      cnt_d = '0;
    end
    if (emit) begin
      next_due_d = next_due_new;
      evt_left_d = evt_left_new;
      rpos_d     = rpos_adv;
      cnt_d      = cnt_inc;
    end
    if (finish_tick) begin
      tick_d = tick_q + 1'b1;
      if (evt_left_d == '0) begin
        rpos_d     = '0;
        evt_left_d = song_len_q;
        next_due_d = '0;
        tick_d     = '0;
      end
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SONG_EVENTS: begin
          song_len_d = cfg_len;
          rpos_d     = '0;
          evt_left_d = cfg_len;
          next_due_d = '0;
          tick_d     = '0;
        end
        CFG_PLAY_ENABLE: begin
          play_en_d  = cfg_data_i[0];
          rpos_d     = '0;
          evt_left_d = song_len_q;
          next_due_d = '0;
          tick_d     = '0;
        end
        default: begin
          song_len_d = song_len_q;
        end
      endcase
    end
  end

  // Output register: load an emitted write, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (wr_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d         = 1'b1;
      out_d.write_address = rd_word.addr;
      out_d.write_data    = rd_word.data;
      out_d.last_write    = !more;
    end
  end

  assign wr_o.valid   = out_valid_q;
  assign wr_o.payload = out_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      song_len_q  <= '0;
      play_en_q   <= 1'b0;
      rpos_q      <= '0;
      evt_left_q  <= '0;
      next_due_q  <= '0;
      tick_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      song_len_q  <= song_len_d;
      play_en_q   <= play_en_d;
      rpos_q      <= rpos_d;
      evt_left_q  <= evt_left_d;
      next_due_q  <= next_due_d;
      tick_q      <= tick_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Emission only runs while events remain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> evt_left_q != '0)
    else $error("emitting with no events left");

  // The write budget of a tick is never exceeded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> cnt_q < MAX_CNT)
    else $error("write budget exceeded");

  // A load never meets a song read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && mem_we))
    else $error("song memory read and write collide");

  // After the last write of a tick the sequencer takes requests again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !more |=> state_q == ST_IDLE && out_valid_q && out_q.last_write)
    else $error("tick not closed after its last write");

  // While idle, a pending write can only be the closing one of its tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && out_valid_q |-> out_q.last_write)
    else $error("unfinished tick left in output register");

endmodule

`default_nettype wire

// File: tb/tb_timed_register_write_sequencer.sv
// Self-checking testbench for the timed register write sequencer.
// Loads songs, plays them under random idling and sink stalls, checks every write.
// Depends on tsq_pkg, tsq_if and the sequencer top level.
`timescale 1ns / 1ps

module tb_timed_register_write_sequencer;
  import tsq_pkg::*;

  localparam int unsigned IDLE_PCT      = 31;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 210;
  localparam int unsigned SHORT_SONG    = 48;
  localparam int unsigned FILL_SLOTS    = 130;

  // Register indexes that the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // Shadow of the song player: song memory, playback position and the writes still owed
  class song_player_shadow;
    song_word_t        song_mem [SONG_DEPTH_DEF];
    int unsigned       song_len;
    bit                play_on;
    int unsigned       play_pos;
    int unsigned       events_left;
    logic [TICK_W-1:0] due_tick;
    logic [TICK_W-1:0] tick_now;
    wr_t               due_writes_q[$];
    int unsigned       fault_count;

    function new();
      song_len    = 0;
      play_on     = 1'b0;
      fault_count = 0;
      rewind();
      events_left = 0;
    endfunction

    function void rewind();
      play_pos    = 0;
      events_left = song_len;
      due_tick    = '0;
      tick_now    = '0;
    endfunction

    function int unsigned pending();
      return due_writes_q.size();
    endfunction

    function void note_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    // A song length or play enable write restarts the song; unknown indexes change nothing
    function void take_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_SONG_EVENTS) begin
        song_len = int'(data);
        if (song_len > SONG_DEPTH_DEF) song_len = SONG_DEPTH_DEF;
        rewind();
      end else if (idx == CFG_PLAY_ENABLE) begin
        play_on = data[0];
        rewind();
      end
    endfunction

    // Store a load, or walk the due events of a tick up to the per-tick cap
    function void take_request(req_t r);
      song_word_t  w;
      wr_t         wr;
      int unsigned n;
      if (r.opcode == OP_LOAD) begin
        if (r.event_index < SONG_DEPTH_DEF) begin
          w.delay = r.delay_ticks;
          w.data  = r.reg_data;
          w.addr  = r.reg_address;
          song_mem[r.event_index] = w;
        end
        return;
      end
      if (!play_on) return;
      n = 0;
      while (events_left != 0 && due_tick <= tick_now && n < MAX_WRITES_DEF) begin
        w = song_mem[play_pos];
        due_tick = tick_now + TICK_W'(w.delay);
        wr.write_address = w.addr;
        wr.write_data    = w.data;
        wr.last_write    = 1'b0;
        due_writes_q.push_back(wr);
        n++;
        play_pos = (play_pos + 1 >= SONG_DEPTH_DEF) ? 0 : play_pos + 1;
        events_left--;
      end
      // Mark the final write of this tick
      if (n != 0) begin
        wr = due_writes_q.pop_back();
        wr.last_write = 1'b1;
        due_writes_q.push_back(wr);
      end
      tick_now++;
      if (events_left == 0) rewind();
    endfunction

    function void check_write(wr_t got);
      wr_t want;
      if (due_writes_q.size() == 0) begin
        note_fault($sformatf("unexpected write: addr=%02h data=%02h last=%0b",
                             got.write_address, got.write_data, got.last_write));
        return;
      end
      want = due_writes_q.pop_front();
      if (got.write_address !== want.write_address || got.write_data !== want.write_data ||
          got.last_write !== want.last_write) begin
        note_fault($sformatf({"write mismatch: expected addr=%02h data=%02h last=%0b, ",
                              "got addr=%02h data=%02h last=%0b"},
                             want.write_address, want.write_data, want.last_write,
                             got.write_address, got.write_data, got.last_write));
      end
    endfunction

    function void close();
      if (due_writes_q.size() != 0)
        note_fault($sformatf("%0d expected writes never arrived", due_writes_q.size()));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  bit                   calm = 1'b1;
  logic                 hold_sink_req = 1'b0;
  song_player_shadow    shadow;

  tsq_req_if req_if ();
  tsq_wr_if  wr_if ();

  timed_register_write_sequencer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .wr_o       (wr_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Request builders
  function automatic req_t tick_request();
    req_t t;
    t.opcode      = OP_TICK;
    t.event_index = IDX_W'($urandom);
    t.reg_address = BYTE_W'($urandom);
    t.reg_data    = BYTE_W'($urandom);
    t.delay_ticks = DELAY_W'($urandom);
    return t;
  endfunction

  function automatic req_t load_request(input logic [IDX_W-1:0] slot,
                                        input logic [BYTE_W-1:0] addr,
                                        input logic [BYTE_W-1:0] data,
                                        input logic [DELAY_W-1:0] delay);
    req_t t;
    t.opcode      = OP_LOAD;
    t.event_index = slot;
    t.reg_address = addr;
    t.reg_data    = data;
    t.delay_ticks = delay;
    return t;
  endfunction

  // Mostly short delays so songs wrap often; now and then long or extreme ones
  function automatic logic [DELAY_W-1:0] song_delay();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return DELAY_W'($urandom_range(0, 2));
    if (pick < 80) return DELAY_W'($urandom_range(3, 12));
    if (pick < 92) return DELAY_W'($urandom_range(13, 300));
    if (pick < 96) return '1;
    return DELAY_W'($urandom);
  endfunction

  // Offer one request, idling at random first; hold valid across back-to-back requests
  task automatic offer_request(input req_t r);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    shadow.take_request(r);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    shadow.take_config(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, wait for every owed write, then let the block settle
  task automatic quiesce();
    int unsigned waited = 0;
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write sink: random stalls, one long hold-off on request, none while calm
  initial begin
    int unsigned hold_left = 0;
    bit          hold_taken = 1'b0;
    wr_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        wr_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_sink_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        wr_if.ready <= 1'b0;
      end else begin
        wr_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Check every accepted write
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && wr_if.valid === 1'b1 && wr_if.ready === 1'b1)
      shadow.check_write(wr_if.payload);
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned random_items;
    int unsigned phase;
    int unsigned song_len;
    int unsigned play_lim;
    int unsigned pick;
    int unsigned steps;
    bit          play_on;
    logic [IDX_W-1:0] slot;

    shadow = new();
    random_items = 0;
    phase = 0;
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= '0;
    cfg_data       <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Play is off after reset: a tick does nothing
    offer_request(tick_request());

    // Fill the low slots; songs that run past them get too few ticks to leave them
    for (int i = 0; i < int'(FILL_SLOTS); i++)
      offer_request(load_request(IDX_W'(i), BYTE_W'($urandom), BYTE_W'($urandom), '0));

    // Oversized length saturates to the full memory; play the start of it
    quiesce();
    write_config(CFG_SONG_EVENTS, '1);
    write_config(CFG_PLAY_ENABLE, CFG_W'(1));
    repeat (2) offer_request(tick_request());
    calm = 1'b0;

    // Four-event song with extreme fields, walked through its loop point
    quiesce();
    write_config(CFG_SONG_EVENTS, CFG_W'(4));
    write_config(CFG_PLAY_ENABLE, CFG_W'(1));
    offer_request(load_request(12'h000, 8'h00, 8'h00, 16'h0000));
    offer_request(load_request(12'h001, 8'hFF, 8'hFF, 16'h0001));
    offer_request(load_request(12'h002, 8'h5A, 8'hA5, 16'h0002));
    offer_request(load_request(12'h003, 8'hC3, 8'h3C, 16'hFFFF));
    repeat (5) offer_request(tick_request());
    // Load the top slot while playing
    offer_request(load_request(12'hFFF, 8'h81, 8'h18, 16'h8000));
    offer_request(tick_request());

    // Writes to undecoded indexes must not restart the song
    quiesce();
    write_config(CFG_SPARE_2, '1);
    write_config(CFG_SPARE_3, '1);
    repeat (2) offer_request(tick_request());

    // Empty song: ticks emit nothing
    quiesce();
    write_config(CFG_SONG_EVENTS, '0);
    repeat (2) offer_request(tick_request());

    // Play off, with the upper data bits set
    quiesce();
    write_config(CFG_PLAY_ENABLE, 13'h1FFE);
    offer_request(tick_request());

    // More due events than one tick may emit
    for (int i = 0; i < 4; i++)
      offer_request(load_request(IDX_W'(i), BYTE_W'($urandom), BYTE_W'($urandom), '0));
    quiesce();
    write_config(CFG_SONG_EVENTS, CFG_W'(70));
    write_config(CFG_PLAY_ENABLE, CFG_W'(1));
    repeat (3) offer_request(tick_request());

    // Random phases: load a song, set it up, then mostly ticks with some loads mixed in
    while (random_items < RANDOM_ITEMS) begin
      quiesce();
      calm = (phase >= 4 && phase <= 6);
      pick = $urandom_range(0, 99);
      if (phase == 1) song_len = 130;
      else if (pick < 6) song_len = 0;
      else if (pick < 10) song_len = ($urandom_range(0, 1) != 0) ? 4096 : 8191;
      else if (pick < 28) song_len = $urandom_range(65, FILL_SLOTS);
      else song_len = $urandom_range(1, SHORT_SONG);
      play_lim = (song_len > SONG_DEPTH_DEF) ? SONG_DEPTH_DEF : song_len;

      for (int i = 0; i < int'(play_lim) && i < int'(SHORT_SONG); i++) begin
        offer_request(load_request(IDX_W'(i), BYTE_W'($urandom), BYTE_W'($urandom),
                                   (phase == 1) ? '0 : song_delay()));
        random_items++;
      end

      quiesce();
      if ($urandom_range(0, 9) == 0)
        write_config(($urandom_range(0, 1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                     CFG_W'($urandom));
      write_config(CFG_SONG_EVENTS, CFG_W'(song_len));
      play_on = (phase == 1) || ($urandom_range(0, 99) < 85);
      write_config(CFG_PLAY_ENABLE, {(CFG_W-1)'($urandom), play_on});

      // Hold the sink off while ticks keep coming, so the block backs up
      if (phase == 1) hold_sink_req <= 1'b1;

      steps = $urandom_range(8, 30);
      // A long song may only tick as far as the filled slots reach
      if (play_lim > FILL_SLOTS) steps = FILL_SLOTS / MAX_WRITES_DEF;
      for (int k = 0; k < int'(steps); k++) begin
        if ($urandom_range(0, 99) < 22) begin
          if (play_lim == 0 || $urandom_range(0, 3) == 0) slot = IDX_W'($urandom);
          else slot = IDX_W'($urandom_range(0, play_lim - 1));
          offer_request(load_request(slot, BYTE_W'($urandom), BYTE_W'($urandom),
                                     song_delay()));
          random_items++;
        end else begin
          offer_request(tick_request());
          random_items++;
        end
      end
      phase++;
    end

    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    shadow.close();
    if (shadow.fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/tsq_pkg.sv
sv/tsq_if.sv
sv/tsq_song_mem.sv
sv/timed_register_write_sequencer.sv
tb/tb_timed_register_write_sequencer.sv
